[sv/mmp_pkg.sv]
package mmp_pkg;

  localparam int unsigned ExpBits   = 63;
  localparam int unsigned ExpIdxW   = $clog2(ExpBits);
  localparam int unsigned EntryW    = 30;
  localparam int unsigned CfgIdxW   = 2;
  localparam logic [29:0] PrimeMod  = 30'd1000000007;
  // floor(2^61 / P), the reciprocal used to estimate the quotient of a product.
  localparam logic [31:0] BarrettM  = 32'd2305842993;

  localparam logic [CfgIdxW-1:0] RegEntry00 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEntry01 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegEntry10 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegEntry11 = 2'd3;

  typedef logic [EntryW-1:0] res_t;

  // Request to the shared multiply-accumulate unit: s = (acc + a * b) mod P.
  typedef struct packed {
    logic start;
    res_t a;
    res_t b;
    res_t acc;
  } mac_req_t;

  typedef struct packed {
    logic done;
    res_t sum;
  } mac_rsp_t;

endpackage

[sv/mmp_if.sv]
interface mmp_exp_if;
  logic                       valid;
  logic                       ready;
  logic [mmp_pkg::ExpBits-1:0] exponent;
  modport source (output valid, output exponent, input ready);
  modport sink   (input valid, input exponent, output ready);
endinterface

interface mmp_res_if;
  logic                      valid;
  logic                      ready;
  logic [mmp_pkg::EntryW-1:0] result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

[sv/mmp_mac.sv]
module mmp_mac
  import mmp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  // One operation: multiply, estimate the quotient by P with a reciprocal
  // multiply, subtract the quotient times P, correct by at most two P, then
  // add the accumulator and subtract once. One multiplier serves all steps.
  typedef enum logic [2:0] {MacIdle, MacMul, MacQuo, MacRem, MacFix, MacAdd} mac_state_e;

  mac_state_e  state_q;
  logic [59:0] prod_q;
  logic [30:0] quo_q;
  logic [31:0] rem_q;
  res_t        red_q;
  res_t        acc_q;
  res_t        b_q;
  res_t        a_q;
  logic        done_q;
  res_t        sum_q;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [62:0] mul_p;
  logic [31:0] rem_m1;
  logic [31:0] rem_m2;
  res_t        red_d;
  logic [30:0] add_s;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      MacMul: begin
        mul_a = {2'b00, a_q};
        mul_b = {2'b00, b_q};
      end
      MacQuo: begin
        mul_a = {1'b0, prod_q[59:29]};
        mul_b = BarrettM;
      end
      MacRem: begin
        mul_a = {1'b0, quo_q};
        mul_b = {2'b00, PrimeMod};
      end
      default: ;
    endcase
  end

  assign mul_p = 63'(mul_a) * 63'(mul_b);

  // The quotient estimate is at most two below the true one, so the remainder
  // is below 3P and fits in 32 bits.
  assign rem_m1 = rem_q - {2'b00, PrimeMod};
  assign rem_m2 = rem_q - {1'b0, PrimeMod, 1'b0};
  assign red_d  = (rem_q >= {1'b0, PrimeMod, 1'b0}) ? rem_m2[29:0] :
                  (rem_q >= {2'b00, PrimeMod})      ? rem_m1[29:0] : rem_q[29:0];
  assign add_s  = {1'b0, red_q} + {1'b0, acc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MacIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MacIdle: begin
          if (req_i.start) begin
            a_q     <= req_i.a;
            b_q     <= req_i.b;
            acc_q   <= req_i.acc;
            state_q <= MacMul;
          end
        end
        MacMul: begin
          prod_q  <= mul_p[59:0];
          state_q <= MacQuo;
        end
        MacQuo: begin
          quo_q   <= mul_p[62:32];
          state_q <= MacRem;
        end
        MacRem: begin
          rem_q   <= prod_q[31:0] - mul_p[31:0];
          state_q <= MacFix;
        end
        MacFix: begin
          red_q   <= red_d;
          state_q <= MacAdd;
        end
        MacAdd: begin
          sum_q   <= (add_s >= {1'b0, PrimeMod}) ? 30'(add_s - {1'b0, PrimeMod})
                                                 : add_s[29:0];
          done_q  <= 1'b1;
          state_q <= MacIdle;
        end
        default: state_q <= MacIdle;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sum  = sum_q;

  a_done_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MacAdd |=> done_q) else $error("mac done missing");
  a_sum_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> sum_q < PrimeMod) else $error("mac sum not reduced");
  a_red_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MacAdd |-> red_q < PrimeMod) else $error("mac remainder not reduced");

endmodule

[sv/mod_matrix_power_2x2_top.sv]
// A request is served by passes through the shared multiply-reduce unit, from the
// accepting edge to a valid result: 4 passes reduce the entries, each of the 63
// squarings and each multiply for a set bit takes 8 passes, and 1 pass forms the
// top row sum.
// Throughput: one request at a time; the next is taken in the cycle after the result left.
// Reset (rst_ni low, asynchronous) loads the matrix entries 2, 1, 0, 4 and idles.
module mod_matrix_power_2x2_top
  import mmp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [EntryW-1:0]   cfg_data_i,
  mmp_exp_if.sink             in_if,
  mmp_res_if.source           out_if
);

  typedef enum logic [2:0] {
    StIdle, StPrep, StIssue, StWait, StFinish, StFinWait, StOut
  } top_state_e;

  top_state_e state_q;
  res_t cfg_q [4];
  res_t base_q [4];
  res_t acc_q [4];
  res_t tmp_q [4];
  logic [ExpBits-1:0] exp_q;
  logic [ExpIdxW-1:0] bit_q;
  logic mulb_q;   // 0: squaring pass, 1: multiply by base
  logic [2:0] op_q;  // entry (2 bits) and term (1 bit)
  logic [1:0] prep_q;
  logic prep_done_q;
  res_t res_q;

  mac_req_t req;
  mac_rsp_t rsp;

  always_comb begin
    req.start = 1'b0;
    req.a     = acc_q[{op_q[2], op_q[0]}];
    req.b     = mulb_q ? base_q[{op_q[0], op_q[1]}] : acc_q[{op_q[0], op_q[1]}];
    req.acc   = op_q[0] ? tmp_q[op_q[2:1]] : '0;
    case (state_q)
      // Reduce each entry modulo P by passing it through the unit times one.
      StPrep: begin
        req.start = 1'b1;
        req.a     = cfg_q[prep_q];
        req.b     = res_t'(1);
        req.acc   = '0;
      end
      StIssue: req.start = 1'b1;
      StFinish: begin
        req.start = 1'b1;
        req.a     = acc_q[0];
        req.b     = res_t'(1);
        req.acc   = acc_q[1];
      end
      default: ;
    endcase
  end

  mmp_mac u_mac (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cfg_q[0]    <= res_t'(2);
      cfg_q[1]    <= res_t'(1);
      cfg_q[2]    <= res_t'(0);
      cfg_q[3]    <= res_t'(4);
      bit_q       <= '0;
      mulb_q      <= 1'b0;
      op_q        <= '0;
      prep_q      <= '0;
      prep_done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegEntry00: cfg_q[0] <= cfg_data_i;
          RegEntry01: cfg_q[1] <= cfg_data_i;
          RegEntry10: cfg_q[2] <= cfg_data_i;
          RegEntry11: cfg_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_if.valid) begin
            exp_q       <= in_if.exponent;
            acc_q[0]    <= res_t'(1);
            acc_q[1]    <= '0;
            acc_q[2]    <= '0;
            acc_q[3]    <= res_t'(1);
            prep_q      <= '0;
            prep_done_q <= 1'b0;
            bit_q       <= ExpIdxW'(ExpBits - 1);
            mulb_q      <= 1'b0;
            op_q        <= '0;
            state_q     <= StPrep;
          end
        end
        StPrep: state_q <= StWait;
        StIssue: state_q <= StWait;
        StWait: begin
          if (rsp.done) begin
            if (!prep_done_q) begin
              base_q[prep_q] <= rsp.sum;
              prep_q <= prep_q + 2'd1;
              if (prep_q == 2'd3) begin
                prep_done_q <= 1'b1;
                state_q     <= StIssue;
              end else begin
                state_q <= StPrep;
              end
            end else begin
              tmp_q[op_q[2:1]] <= rsp.sum;
              op_q <= op_q + 3'd1;
              if (op_q != 3'd7) begin
                state_q <= StIssue;
              end else begin
                acc_q[0] <= tmp_q[0];
                acc_q[1] <= tmp_q[1];
                acc_q[2] <= tmp_q[2];
                acc_q[3] <= rsp.sum;
                if (!mulb_q && exp_q[bit_q]) begin
                  mulb_q  <= 1'b1;
                  state_q <= StIssue;
                end else begin
                  mulb_q <= 1'b0;
                  if (bit_q == '0) begin
                    state_q <= StFinish;
                  end else begin
                    bit_q   <= bit_q - ExpIdxW'(1);
                    state_q <= StIssue;
                  end
                end
              end
            end
          end
        end
        StFinish: state_q <= StFinWait;
        StFinWait: begin
          if (rsp.done) begin
            res_q   <= rsp.sum;
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_if.ready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_if.ready   = (state_q == StIdle);
  assign out_if.valid  = (state_q == StOut);
  assign out_if.result = res_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("accept while result pending");
  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.result < PrimeMod) else $error("result not reduced");
  a_idle_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready |=> in_if.ready) else $error("no return to idle");

endmodule
